// ----- hdl/multi_channel_servo_slew_ramp_assert.svh -----
// Assertion macros for the servo slew ramp.
// Needs nothing else; included inside module bodies.
`ifndef MULTI_CHANNEL_SERVO_SLEW_RAMP_ASSERT_SVH
`define MULTI_CHANNEL_SERVO_SLEW_RAMP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MCSSR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: lbl");

// next-cycle implication, checked outside reset
`define MCSSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: lbl");

`endif

// ----- hdl/mcssr_pkg.sv -----
// Package for the servo slew ramp: channel count, sequencer states,
// per-channel center and direction tables. No dependencies.
package mcssr_pkg;

   localparam int CHANNELS = 12;
   localparam logic [13:0] PULSE_MAX = 14'd16383;
   localparam logic [7:0] PPD_RESET = 8'd38;
   localparam logic [7:0] PERIOD_RESET = 8'd10;
   localparam logic [7:0] DIVIDER_RESET = 8'd2;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET = 1'b1;

   localparam logic CSR_PPD = 1'b0;
   localparam logic CSR_PERIOD = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_MOD,
      S_STEP,
      S_FBLOAD,
      S_FB,
      S_LATCH,
      S_SEND
   } state_type;

   function automatic logic [13:0] chan_center(input logic [3:0] ch);
      logic [13:0] c;
      case (ch)
         4'd2, 4'd5: c = 14'd5164;
         4'd4:       c = 14'd4860;
         4'd6:       c = 14'd4898;
         4'd7:       c = 14'd5278;
         4'd8:       c = 14'd5392;
         4'd10:      c = 14'd4936;
         4'd11:      c = 14'd5202;
         default:    c = 14'd5050;
      endcase
      return c;
   endfunction

   // 1 where the channel runs mirrored
   function automatic logic chan_neg(input logic [3:0] ch);
      logic n;
      case (ch)
         4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd9: n = 1'b1;
         default: n = 1'b0;
      endcase
      return n;
   endfunction

endpackage

// ----- hdl/multi_channel_servo_slew_ramp.sv -----
// Twelve-channel servo ramp: one sequencer drives one shared bit-serial divider.
// A set beat is taken in S_IDLE and req_tready stays high after it.
// A tick beat is accepted in S_IDLE, then each channel runs a load, 16 divide steps,
// a ramp step and a send, plus a feedback load, 16 more divide steps and a latch
// when feedback refreshes. Each send also waits on rsp_tready.
// Reset (synchronous, active high): pulses and targets at centers, dividers 2.
module multi_channel_servo_slew_ramp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // channel[3:0], angle_deg[11:4], step_divider[19:12]
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // out_channel[3:0], pulse[17:4], feedback_angle[25:18]
   output logic        rsp_tuser,  // feedback_fresh
   output logic        rsp_tlast,  // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   import mcssr_pkg::*;

   state_type state_ff, state_in;
   logic [15:0] tick_ff, tick_in, mark_ff, mark_in;
   logic [7:0]  ppd_ff, period_ff;
   logic [3:0]  ch_ff, ch_in, cnt_ff, cnt_in;
   logic [15:0] num_ff, num_in;
   logic [7:0]  den_ff, den_in, rem_ff, rem_in;
   logic        neg_ff, neg_in, fresh_ff, fresh_in;

   logic [13:0]       pulse_ff [CHANNELS];
   logic [13:0]       target_ff [CHANNELS];
   logic [7:0]        divider_ff [CHANNELS];
   logic signed [7:0] latch_ff [CHANNELS];

   logic [3:0]  req_channel;
   logic signed [7:0] req_angle;
   logic [7:0]  req_div;
   logic        set_we, step_we, latch_we;
   logic [13:0] set_target, step_pulse;
   logic signed [7:0] latch_val;
   logic signed [16:0] prod;
   logic signed [18:0] tgt_full;
   logic [8:0]  trial, trial_sub;
   logic        trial_ge;
   logic signed [14:0] diff;
   logic [13:0] cur_pulse, cur_target;
   logic [15:0] tick_next;

   assign req_channel = req_tdata[3:0];
   assign req_angle   = req_tdata[11:4];
   assign req_div     = req_tdata[19:12];

   assign cur_pulse  = pulse_ff[ch_ff];
   assign cur_target = target_ff[ch_ff];
   assign tick_next  = tick_ff + 16'd1;

   // target = center +/- angle * ppd, clamped
   assign prod = req_angle * $signed({1'b0, ppd_ff});
   always_comb begin
      logic signed [18:0] off;
      off = chan_neg(req_channel) ? -19'(prod) : 19'(prod);
      tgt_full = $signed({5'b0, chan_center(req_channel)}) + off;
      if (tgt_full < 0) begin
         set_target = '0;
      end else if (tgt_full > $signed({5'b0, PULSE_MAX})) begin
         set_target = PULSE_MAX;
      end else begin
         set_target = tgt_full[13:0];
      end
   end

   // one restoring division step
   assign trial     = {rem_ff, num_ff[15]};
   assign trial_ge  = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   assign diff = $signed({1'b0, cur_pulse}) - $signed({1'b0, chan_center(ch_ff)});

   always_comb begin
      state_in = state_ff;
      tick_in  = tick_ff;
      mark_in  = mark_ff;
      ch_in    = ch_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      fresh_in = fresh_ff;
      set_we   = 1'b0;
      step_we  = 1'b0;
      latch_we = 1'b0;
      step_pulse = cur_pulse;
      latch_val  = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == CMD_SET) begin
                  set_we = 32'(req_channel) < CHANNELS;
               end else begin
                  tick_in  = tick_next;
                  fresh_in = (mark_ff + {8'b0, period_ff}) == tick_next;
                  if (fresh_in) begin
                     mark_in = tick_next;
                  end
                  ch_in    = '0;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            num_in   = tick_ff;
            den_in   = (divider_ff[ch_ff] == 8'd0) ? 8'd1 : divider_ff[ch_ff];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_MOD;
         end
         S_MOD, S_FB: begin
            rem_in = trial_ge ? trial_sub[7:0] : trial[7:0];
            num_in = {num_ff[14:0], trial_ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = (state_ff == S_MOD) ? S_STEP : S_LATCH;
            end
         end
         S_STEP: begin
            if (rem_ff == 8'd0) begin
               step_we = 1'b1;
               if (cur_target > cur_pulse) begin
                  step_pulse = cur_pulse + 14'd1;
               end else if (cur_target < cur_pulse) begin
                  step_pulse = cur_pulse - 14'd1;
               end
            end
            state_in = fresh_ff ? S_FBLOAD : S_SEND;
         end
         S_FBLOAD: begin
            // quotient of the magnitude, sign applied afterward
            neg_in   = diff[14] ^ chan_neg(ch_ff);
            num_in   = diff[14] ? 16'(-diff) : 16'(diff);
            den_in   = (ppd_ff == 8'd0) ? 8'd1 : ppd_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_FB;
         end
         S_LATCH: begin
            latch_we = 1'b1;
            if (!neg_ff) begin
               latch_val = (num_ff > 16'd127) ? 8'sd127 : $signed(num_ff[7:0]);
            end else begin
               latch_val = (num_ff > 16'd128) ? -8'sd128 : $signed(8'(~num_ff[7:0] + 8'd1));
            end
            state_in = S_SEND;
         end
         S_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (32'(ch_ff) == CHANNELS - 1) begin
                  state_in = S_IDLE;
               end else begin
                  ch_in    = ch_ff + 4'd1;
                  state_in = S_LOAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         tick_ff   <= '0;
         mark_ff   <= '0;
         ch_ff     <= '0;
         fresh_ff  <= 1'b0;
         ppd_ff    <= PPD_RESET;
         period_ff <= PERIOD_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            pulse_ff[i]   <= chan_center(4'(i));
            target_ff[i]  <= chan_center(4'(i));
            divider_ff[i] <= DIVIDER_RESET;
            latch_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         mark_ff  <= mark_in;
         ch_ff    <= ch_in;
         fresh_ff <= fresh_in;
         if (csr_valid) begin
            if (csr_index == CSR_PPD) begin
               ppd_ff <= csr_data;
            end else begin
               period_ff <= csr_data;
            end
         end
         if (set_we) begin
            target_ff[req_channel]  <= set_target;
            divider_ff[req_channel] <= req_div;
         end
         if (step_we) begin
            pulse_ff[ch_ff] <= step_pulse;
         end
         if (latch_we) begin
            latch_ff[ch_ff] <= latch_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign rsp_tdata = {6'b0, latch_ff[ch_ff], cur_pulse, ch_ff};
   assign rsp_tuser = fresh_ff;
   assign rsp_tlast = (32'(ch_ff) == CHANNELS - 1);

`include "multi_channel_servo_slew_ramp_assert.svh"

   `MCSSR_ASSERT_NOW(no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `MCSSR_ASSERT_NEXT(idle_after_last, clock, reset,
      rsp_tvalid && rsp_tready && rsp_tlast, req_tready)
   `MCSSR_ASSERT_NEXT(step_after_mod, clock, reset,
      state_ff == S_MOD && cnt_ff == 4'd15, state_ff == S_STEP)
   `MCSSR_ASSERT_NEXT(fresh_holds, clock, reset,
      state_ff != S_IDLE && state_in != S_IDLE, $stable(fresh_ff))

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the twelve-channel servo slew ramp.
// Depends on mcssr_pkg and multi_channel_servo_slew_ramp; needs no other files.
`timescale 1ns / 100ps

module tb_top;
   import mcssr_pkg::*;

   typedef struct packed {
      logic       cmd;
      logic [3:0] chan;
      logic [7:0] angle;
      logic [7:0] div;
   } servo_cmd_type;

   typedef struct packed {
      logic [3:0]  chan;
      logic [13:0] pulse;
      logic [7:0]  fb;
      logic        fresh;
      logic        last;
   } chan_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_data = '0;

   multi_channel_servo_slew_ramp dut (.*);

   always #10 clock = ~clock;

   // shadow state of the ramp
   int          ppd, period;
   int          pulse_now [CHANNELS];
   int          pulse_goal [CHANNELS];
   int          divider [CHANNELS];
   int          angle_latch [CHANNELS];
   int          tick_count, refresh_mark;

   servo_cmd_type   cmd_queue [$];
   chan_report_type report_queue [$];
   int           mismatches = 0;
   int           cycles = 0;
   int           burst_left = 0, gap_left = 0;
   int           stall_mode = 0;

   function automatic int center_of(int ch);
      return int'(chan_center(ch[3:0]));
   endfunction

   function automatic int sign_of(int ch);
      return chan_neg(ch[3:0]) ? -1 : 1;
   endfunction

   task automatic predict(input servo_cmd_type c);
      int  goal, d, q, ch;
      bit  fresh;
      chan_report_type r;
      if (c.cmd == CMD_SET) begin
         if (c.chan < CHANNELS) begin
            goal = center_of(c.chan) + sign_of(c.chan) * $signed(c.angle) * ppd;
            if (goal < 0) goal = 0;
            if (goal > 16383) goal = 16383;
            pulse_goal[c.chan] = goal;
            divider[c.chan] = c.div;
         end
      end else begin
         tick_count = (tick_count + 1) & 16'hFFFF;
         for (ch = 0; ch < CHANNELS; ch++) begin
            d = divider[ch] == 0 ? 1 : divider[ch];
            if (tick_count % d == 0) begin
               if (pulse_goal[ch] > pulse_now[ch]) pulse_now[ch]++;
               else if (pulse_goal[ch] < pulse_now[ch]) pulse_now[ch]--;
            end
         end
         fresh = ((refresh_mark + period) & 16'hFFFF) == tick_count;
         if (fresh) begin
            refresh_mark = tick_count;
            for (ch = 0; ch < CHANNELS; ch++) begin
               q = (pulse_now[ch] - center_of(ch)) / (ppd == 0 ? 1 : ppd);
               q = q * sign_of(ch);
               if (q > 127) q = 127;
               if (q < -128) q = -128;
               angle_latch[ch] = q;
            end
         end
         for (ch = 0; ch < CHANNELS; ch++) begin
            r.chan = ch[3:0];
            r.pulse = pulse_now[ch][13:0];
            r.fb = angle_latch[ch][7:0];
            r.fresh = fresh;
            r.last = (ch == CHANNELS - 1);
            report_queue.push_back(r);
         end
      end
   endtask

   // driver: bursts with random gaps; prediction on each accepted beat
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict(servo_cmd_type'({req_tuser, req_tdata[3:0], req_tdata[11:4],
               req_tdata[19:12]}));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser <= cmd_queue[0].cmd;
               req_tdata <= {4'b0, cmd_queue[0].div, cmd_queue[0].angle,
                             cmd_queue[0].chan};
               void'(cmd_queue.pop_front());
               if (burst_left > 0) burst_left <= burst_left - 1;
               else begin
                  burst_left <= $urandom_range(0, 6);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor with its own stall pattern
   always @(posedge clock) begin
      chan_report_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[3:0], rsp_tdata[17:4], rsp_tdata[25:18], rsp_tuser,
                   rsp_tlast};
            if (report_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat %h", got);
            end else begin
               want = report_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ch %0d: expected pulse %0d fb %0d fresh %b last %b, ",
                        "got ch %0d pulse %0d fb %0d fresh %b last %b"},
                        want.chan, want.pulse, $signed(want.fb), want.fresh, want.last,
                        got.chan, got.pulse, $signed(got.fb), got.fresh, got.last);
               end
            end
         end
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= (cycles % 7 < 2);
         endcase
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic servo_cmd_type make_set(int ch, int ang, int dv);
      servo_cmd_type c;
      c.cmd = CMD_SET;
      c.chan = ch[3:0];
      c.angle = ang[7:0];
      c.div = dv[7:0];
      return c;
   endfunction

   function automatic servo_cmd_type make_tick();
      servo_cmd_type c;
      c = '0;
      c.cmd = CMD_TICK;
      c.chan = 4'($urandom_range(0, 15));
      c.angle = 8'($urandom);
      c.div = 8'($urandom);
      return c;
   endfunction

   task automatic drain();
      while (cmd_queue.size() > 0 || req_tvalid || report_queue.size() > 0)
         @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[7:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_PPD) ppd = val;
      else period = val;
      @(posedge clock);
   endtask

   initial begin
      int ch, n, k;
      ppd = 38;
      period = 10;
      for (ch = 0; ch < CHANNELS; ch++) begin
         pulse_now[ch] = center_of(ch);
         pulse_goal[ch] = center_of(ch);
         divider[ch] = 2;
         angle_latch[ch] = 0;
      end
      tick_count = 0;
      refresh_mark = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero divider, ignored channels, clamping
      cmd_queue.push_back(make_set(0, 127, 0));
      cmd_queue.push_back(make_set(1, -128, 1));
      cmd_queue.push_back(make_set(2, 0, 255));
      cmd_queue.push_back(make_set(12, 50, 3));
      cmd_queue.push_back(make_set(15, -1, 3));
      for (k = 0; k < 12; k++) cmd_queue.push_back(make_tick());
      drain();
      write_reg(CSR_PPD, 255);
      write_reg(CSR_PERIOD, 1);
      cmd_queue.push_back(make_set(3, 127, 1));
      cmd_queue.push_back(make_set(4, 127, 1));
      cmd_queue.push_back(make_set(5, -128, 1));
      for (k = 0; k < 5; k++) cmd_queue.push_back(make_tick());
      drain();

      // random phases with varied registers; a missed refresh is allowed
      for (n = 0; n < 6; n++) begin
         case (n)
            0: begin write_reg(CSR_PPD, 1); write_reg(CSR_PERIOD, 255); end
            1: begin write_reg(CSR_PPD, 2); write_reg(CSR_PERIOD, 3); end
            default: begin
               write_reg(CSR_PPD, $urandom_range(1, 255));
               write_reg(CSR_PERIOD, $urandom_range(1, 20));
            end
         endcase
         for (k = 0; k < 70; k++) begin
            if ($urandom_range(0, 2) == 0)
               cmd_queue.push_back(make_set($urandom_range(0, 15), $urandom,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3)));
            else
               cmd_queue.push_back(make_tick());
         end
         drain();
      end
      write_reg(CSR_PPD, 38);
      write_reg(CSR_PERIOD, 10);

      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
